// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// No dependencies; the files that assert include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low asynchronous reset
`define ASSERT_CLK_RST(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) \
		else $error(msg);

// Concurrent assertion on the block clock clk and reset arst_n
`define ASSERT_STD(label, prop, msg) \
	`ASSERT_CLK_RST(label, clk, arst_n, prop, msg)

`endif

// ----- rtl/fes_pkg.sv -----
// Package of the fire effect stencil: register codes, field widths and constants.
// No dependencies; used by fire_effect_stencil.
package fes_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_LINE_WIDTH   = 2'd0,
		CFG_FIRE_ROWS    = 2'd1,
		CFG_DECAY_OFFSET = 2'd2
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int LW_W       = 11;
	localparam int ROWS_W     = 10;
	localparam int OFS_W      = 10;
	localparam int PIX_W      = 8;
	localparam int POS_W      = 20;
	localparam int SUM_W      = 11;

	localparam logic [POS_W-1:0]  POS_MAX   = '1;
	localparam logic [LW_W-1:0]   LW_RESET  = 11'd160;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 10'd96;
	localparam logic [OFS_W-1:0]  OFS_RESET = 10'd8;

	localparam int WIDTH_MIN = 2;
	localparam logic [ROWS_W-1:0] ROWS_MIN = 10'd1;
	localparam logic [ROWS_W-1:0] ROWS_MAX = 10'd1022;

	// decay table span: sums at or above it decay to zero
	localparam logic [SUM_W-1:0] TABLE_SIZE = 11'd1280;

	// divide by five as multiply by 3277 and shift by 14, exact for any 11-bit value
	localparam int DIV5_MUL   = 3277;
	localparam int DIV5_SHIFT = 14;
	localparam int PROD_W     = SUM_W + 12;

endpackage

// ----- rtl/fire_effect_stencil.sv -----
// Fire effect five-tap decay stencil, top level.
// Depends on fes_pkg and assert_macros.svh.
//
// Channel  Signals                          Direction  Payload
// input    in_valid / in_ready              in         pixel_in, frame_start
// output   out_valid / out_ready            out        pixel_out, was_updated
// config   cfg_we, cfg_index, cfg_data      in         line_width, fire_rows, decay_offset
//
// One pixel per clock while the output is not stalled; a transaction passes stage 1
// (RAM read at its accepting edge), stage 2 (tap sum) and the output register (divide by five).
// The window is one RAM of 2^$clog2(2*MAX_WIDTH) words, each a pixel and its two
// predecessors, so two reads per cycle deliver all five taps.
// Reset clears only control state; taps older than the frame are masked by position.
// Each stage stalls only while the stage after it is full and blocked.
`include "assert_macros.svh"

module fire_effect_stencil #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fes_pkg::PIX_W-1:0]         pixel_in,
	input  logic                              frame_start,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fes_pkg::PIX_W-1:0]         pixel_out,
	output logic                              was_updated,
	// configuration
	input  logic                              cfg_we,
	input  logic [fes_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fes_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int PW    = fes_pkg::POS_W;
	localparam int DW    = fes_pkg::PIX_W;
	localparam int SW    = fes_pkg::SUM_W;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CW    = (WW > fes_pkg::LW_W) ? WW : fes_pkg::LW_W;
	localparam int FW    = WW + fes_pkg::ROWS_W + 1;
	localparam int CMPW  = (FW > PW) ? FW : PW;
	localparam int AW    = $clog2(2 * MAX_WIDTH);
	localparam int DEPTH = 1 << AW;
	localparam int MW    = 3 * DW;

	// ---------------------------------------------------------------
	// configuration registers
	logic [fes_pkg::LW_W-1:0]   line_width_q;
	logic [fes_pkg::ROWS_W-1:0] fire_rows_q;
	logic [fes_pkg::OFS_W-1:0]  decay_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= fes_pkg::LW_RESET;
			fire_rows_q    <= fes_pkg::ROWS_RESET;
			decay_offset_q <= fes_pkg::OFS_RESET;
		end else if (cfg_we) begin
			case (fes_pkg::cfg_idx_t'(cfg_index))
				fes_pkg::CFG_LINE_WIDTH:   line_width_q   <= cfg_data[fes_pkg::LW_W-1:0];
				fes_pkg::CFG_FIRE_ROWS:    fire_rows_q    <= cfg_data[fes_pkg::ROWS_W-1:0];
				fes_pkg::CFG_DECAY_OFFSET: decay_offset_q <= cfg_data[fes_pkg::OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// handshake: each stage loads when empty or when its successor moves
	logic s1_v, s2_v, out_valid_q;
	logic out_rdy, s2_rdy, s1_rdy, in_fire;

	assign out_rdy  = !out_valid_q || out_ready;
	assign s2_rdy   = !s2_v || out_rdy;
	assign s1_rdy   = !s1_v || s2_rdy;
	assign in_ready = s1_rdy;
	assign in_fire  = in_valid && s1_rdy;

	// ---------------------------------------------------------------
	// effective width, rows and frame length
	logic [CW-1:0]               lw_ext;
	logic [WW-1:0]               w_eff;
	logic [fes_pkg::ROWS_W-1:0]  r_eff;
	logic [fes_pkg::ROWS_W:0]    r_p2;
	logic [FW-1:0]               frame_len;
	logic [WW:0]                 two_w;
	logic [WW:0]                 two_w_m1;

	always_comb begin
		lw_ext = CW'(line_width_q);
		if (lw_ext < CW'(fes_pkg::WIDTH_MIN))
			w_eff = WW'(fes_pkg::WIDTH_MIN);
		else if (lw_ext > CW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = lw_ext[WW-1:0];

		if (fire_rows_q < fes_pkg::ROWS_MIN)
			r_eff = fes_pkg::ROWS_MIN;
		else if (fire_rows_q > fes_pkg::ROWS_MAX)
			r_eff = fes_pkg::ROWS_MAX;
		else
			r_eff = fire_rows_q;

		r_p2      = {1'b0, r_eff} + (fes_pkg::ROWS_W + 1)'(2);
		frame_len = FW'(w_eff) * FW'(r_p2);
		two_w     = {w_eff, 1'b0};
		two_w_m1  = two_w - (WW + 1)'(1);
	end

	// ---------------------------------------------------------------
	// position within the frame and RAM write pointer
	logic [PW-1:0] pos_q;
	logic [AW-1:0] ptr_q;
	logic [PW-1:0] pos_eff;
	logic [CMPW-1:0] pos_c;
	logic          upd_c, m2w_c;
	logic [AW-1:0] ra_near, ra_far;

	always_comb begin
		pos_eff = frame_start ? '0 : pos_q;
		pos_c   = CMPW'(pos_eff);
		upd_c   = (pos_c >= CMPW'(two_w_m1)) && (pos_c < CMPW'(frame_len));
		// tap 2W exists only once more than 2W pixels of the frame have arrived
		m2w_c   = pos_c > CMPW'(two_w);
		// word of the step W-1 back holds taps W-2, W-1, W
		ra_near = ptr_q - AW'(w_eff - WW'(1));
		// word of the step 2W-1 back holds taps 2W-2, 2W-1, 2W
		ra_far  = ptr_q - AW'(two_w_m1);
	end

	logic [DW-1:0] hist1_q, hist2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ptr_q <= '0;
		end else if (in_fire) begin
			ptr_q <= ptr_q + AW'(1);
			if (pos_eff != fes_pkg::POS_MAX)
				pos_q <= pos_eff + PW'(1);
			else
				pos_q <= pos_eff;
		end
	end

	// last two accepted pixels, packed next to the new one in each RAM word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			hist1_q <= pixel_in;
			hist2_q <= hist1_q;
		end
	end

	// ---------------------------------------------------------------
	// window RAM: one write, two reads per cycle. Reads always hit words written
	// at earlier transactions and never the word written at the same edge.
	logic [MW-1:0] win_mem [DEPTH];
	logic [MW-1:0] near_s1, far_s1;

	always_ff @(posedge clk) begin
		if (in_fire)
			win_mem[ptr_q] <= {hist2_q, hist1_q, pixel_in};
		if (s1_rdy) begin
			near_s1 <= win_mem[ra_near];
			far_s1  <= win_mem[ra_far];
		end
	end

	// ---------------------------------------------------------------
	// stage 1: control alongside the RAM read
	logic          upd_s1, m2w_s1;
	logic [DW-1:0] px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v <= 1'b0;
		else if (s1_rdy)
			s1_v <= in_fire;
	end

	always_ff @(posedge clk) begin
		if (s1_rdy) begin
			upd_s1 <= upd_c;
			m2w_s1 <= m2w_c;
			px_s1  <= pixel_in;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: five-tap sum and decay offset
	logic [SW-1:0] sum_c;
	logic [SW-1:0] diff_c;
	logic          zero_c;
	logic [DW-1:0] tap_2w;

	always_comb begin
		tap_2w = m2w_s1 ? far_s1[3*DW-1:2*DW] : '0;
		sum_c  = SW'(near_s1[DW-1:0]) + SW'(near_s1[2*DW-1:DW]) +
		         SW'(near_s1[3*DW-1:2*DW]) + SW'(far_s1[DW-1:0]) + SW'(tap_2w);
		zero_c = (sum_c <= SW'(decay_offset_q)) || (sum_c >= fes_pkg::TABLE_SIZE);
		diff_c = sum_c - SW'(decay_offset_q);
	end

	logic          upd_s2, zero_s2;
	logic [SW-1:0] diff_s2;
	logic [DW-1:0] px_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_v <= 1'b0;
		else if (s2_rdy)
			s2_v <= s1_v;
	end

	always_ff @(posedge clk) begin
		if (s2_rdy) begin
			upd_s2  <= upd_s1;
			zero_s2 <= zero_c;
			diff_s2 <= diff_c;
			px_s2   <= px_s1;
		end
	end

	// ---------------------------------------------------------------
	// output register: divide by five, or pass the pixel through
	logic [fes_pkg::PROD_W-1:0] prod_c;
	logic [DW-1:0]              res_c;
	logic [DW-1:0]              pixel_out_q;
	logic                       was_updated_q;

	always_comb begin
		prod_c = fes_pkg::PROD_W'(diff_s2) * fes_pkg::PROD_W'(fes_pkg::DIV5_MUL);
		if (!upd_s2)
			res_c = px_s2;
		else if (zero_s2)
			res_c = '0;
		else
			res_c = prod_c[fes_pkg::DIV5_SHIFT +: DW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_rdy)
			out_valid_q <= s2_v;
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			pixel_out_q   <= res_c;
			was_updated_q <= upd_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pixel_out_q;
	assign was_updated = was_updated_q;

	// ---------------------------------------------------------------
	// assertions
	`ASSERT_STD(a_stall_full, !in_ready |-> (s1_v && s2_v && out_valid_q), "input stalled with a bubble in the pipeline")
	`ASSERT_STD(a_ptr_step, in_fire |=> (ptr_q == $past(ptr_q) + AW'(1)), "write pointer did not advance on a transaction")
	`ASSERT_STD(a_pos_step, (in_fire && !frame_start && pos_q != fes_pkg::POS_MAX) |=> (pos_q == $past(pos_q) + PW'(1)), "position did not advance")
	`ASSERT_STD(a_pos_start, (in_fire && frame_start) |=> (pos_q == PW'(1)), "frame start did not restart the position")

endmodule

// ----- verif/fire_effect_stencil_test.sv -----
// Self-checking testbench for fire_effect_stencil: streams fire frames through the block
// and compares every result with a predictor of the five-tap decay stencil.
// Depends on fes_pkg and the fire_effect_stencil RTL.
module fire_effect_stencil_test;

	localparam int PIX_W      = fes_pkg::PIX_W;
	localparam int CFG_IDX_W  = fes_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = fes_pkg::CFG_DATA_W;
	localparam int LW_W       = fes_pkg::LW_W;
	localparam int ROWS_W     = fes_pkg::ROWS_W;
	localparam int OFS_W      = fes_pkg::OFS_W;
	localparam int POS_W      = fes_pkg::POS_W;

	localparam int MAX_WIDTH = 1024;
	localparam int WIN_DEPTH = 2 * MAX_WIDTH + 2;
	localparam int DECAY_DIV = 5;
	localparam int RANDOM_PIXELS = 900;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             upd;
	} fire_px_t;

	typedef enum int {FRM_FULL, FRM_CUT, FRM_OVERRUN, FRM_NOISE} frame_kind_t;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      pixel_in    = '0;
	logic                  frame_start = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [PIX_W-1:0]      pixel_out;
	logic                  was_updated;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	// predictor state: register copies, pixel history, frame position
	logic [LW_W-1:0]   lw_reg   = fes_pkg::LW_RESET;
	logic [ROWS_W-1:0] rows_reg = fes_pkg::ROWS_RESET;
	logic [OFS_W-1:0]  ofs_reg  = fes_pkg::OFS_RESET;
	logic [PIX_W-1:0]  win_mem [WIN_DEPTH];
	int unsigned       win_head = 0;
	int unsigned       win_fill = 0;
	logic [POS_W-1:0]  frame_pos = '0;

	fire_px_t pending_pixels[$];

	// run control and statistics
	bit src_idle_on  = 1'b0;
	bit sink_idle_on = 1'b0;
	int stall_left   = 0;
	int err_count    = 0;
	int results_seen = 0;
	int updates_seen = 0;
	int pixels_sent  = 0;
	int frames_sent  = 0;
	int settings_used = 0;

	fire_effect_stencil #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_in   (pixel_in),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.was_updated(was_updated),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous bound on the whole run
	initial begin
		#2_000_000;
		$display("fire_effect_stencil_test failed");
		$finish;
	end

	// old pixel j+1 places above the current one; slots not written this frame read zero
	function automatic int unsigned win_tap(input int unsigned j);
		if (j >= win_fill)
			return 0;
		return 32'(win_mem[(win_head + j) % WIN_DEPTH]);
	endfunction

	// decay stencil for one accepted pixel, then history and position update
	task automatic apply_stencil(input logic [PIX_W-1:0] px, input logic fs);
		int unsigned w, r, flen, s;
		fire_px_t    res;
		w = lw_reg;
		if (w < fes_pkg::WIDTH_MIN)
			w = fes_pkg::WIDTH_MIN;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		r = rows_reg;
		if (r < fes_pkg::ROWS_MIN)
			r = fes_pkg::ROWS_MIN;
		if (r > fes_pkg::ROWS_MAX)
			r = fes_pkg::ROWS_MAX;
		flen = w * (r + 2);
		if (fs) begin
			win_fill = 0;
			frame_pos = '0;
		end
		if (frame_pos >= 2 * w - 1 && frame_pos < flen) begin
			s = win_tap(w - 2) + win_tap(w - 1) + win_tap(w) + win_tap(2 * w - 2) +
				win_tap(2 * w);
			res.upd = 1'b1;
			if (s >= fes_pkg::TABLE_SIZE || s <= ofs_reg)
				res.pix = '0;
			else
				res.pix = PIX_W'((s - ofs_reg) / DECAY_DIV);
		end else begin
			res.pix = px;
			res.upd = 1'b0;
		end
		pending_pixels.push_back(res);
		win_head = (win_head + WIN_DEPTH - 1) % WIN_DEPTH;
		win_mem[win_head] = px;
		if (win_fill < WIN_DEPTH)
			win_fill++;
		if (frame_pos != fes_pkg::POS_MAX)
			frame_pos++;
	endtask

	// one input transaction, with an optional idle burst in front
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_in    <= px;
		frame_start <= fs;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_stencil(px, fs);
		pixels_sent++;
	endtask

	task automatic stop_input;
		in_valid <= 1'b0;
	endtask

	// wait for every predicted result, bounded so a lost result is reported
	task automatic drain_results;
		int guard;
		guard = 0;
		while (pending_pixels.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_pixels.size() != 0) begin
			err_count++;
			$display("%0d results never arrived", pending_pixels.size());
			pending_pixels.delete();
		end
	endtask

	// write all three registers; only called while the block is idle
	task automatic program_regs(input logic [LW_W-1:0] lw_v, input logic [ROWS_W-1:0] rows_v,
		input logic [OFS_W-1:0] ofs_v);
		cfg_we    <= 1'b1;
		cfg_index <= fes_pkg::CFG_LINE_WIDTH;
		cfg_data  <= CFG_DATA_W'(lw_v);
		@(posedge clk);
		lw_reg = lw_v;
		cfg_index <= fes_pkg::CFG_FIRE_ROWS;
		cfg_data  <= CFG_DATA_W'(rows_v);
		@(posedge clk);
		rows_reg = rows_v;
		cfg_index <= fes_pkg::CFG_DECAY_OFFSET;
		cfg_data  <= CFG_DATA_W'(ofs_v);
		@(posedge clk);
		ofs_reg = ofs_v;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// hot pixels are favored so that tap sums clear the offset often
	function automatic logic [PIX_W-1:0] rand_px();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return PIX_W'($urandom_range(0, 255));
		if (pick < 8)
			return PIX_W'($urandom_range(200, 255));
		return (pick == 8) ? '0 : '1;
	endfunction

	// output side: random stall bursts while sink idling is on
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result checker: oldest prediction against each accepted output transaction
	always @(posedge clk) begin
		fire_px_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_pixels.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("unexpected result: pixel_out %0d was_updated %0b",
						pixel_out, was_updated);
			end else begin
				want = pending_pixels.pop_front();
				if (want.upd)
					updates_seen++;
				if (pixel_out !== want.pix || was_updated !== want.upd) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("result %0d: pixel_out %0d exp %0d, was_updated %0b exp %0b",
							results_seen, pixel_out, want.pix, was_updated, want.upd);
				end
			end
		end
	end

	// reset register values, pixels sent before any frame start
	task automatic test_reset_config;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		repeat (340)
			send_pixel(rand_px(), 1'b0);
		stop_input();
		drain_results();
	endtask

	// smallest frame, zero and maximum offsets, restart, overrun, width and rows at top
	task automatic test_small_frame_extremes;
		program_regs(11'd2, 10'd1, 10'd0);
		for (int i = 0; i < 6; i++)
			send_pixel('1, i == 0);
		send_pixel(8'h5A, 1'b0);
		send_pixel(8'hA5, 1'b0);
		stop_input();
		drain_results();

		// width and rows below range, offset at the largest value the register holds
		program_regs(11'd1, 10'd0, 10'd1023);
		for (int i = 0; i < 3; i++)
			send_pixel('1, i == 0);
		for (int i = 0; i < 6; i++)
			send_pixel('1, i == 0);
		stop_input();
		drain_results();

		// width and rows above range
		program_regs(11'd2047, 10'd1023, 10'd800);
		send_pixel('1, 1'b1);
		send_pixel('0, 1'b0);
		send_pixel('1, 1'b0);
		send_pixel(8'h81, 1'b0);
		stop_input();
		drain_results();
		frames_sent += 4;
	endtask

	// register changes inside a frame take effect on the kept history
	task automatic test_mid_frame_change;
		program_regs(11'd4, 10'd3, 10'd4);
		for (int i = 0; i < 10; i++)
			send_pixel(rand_px(), i == 0);
		stop_input();
		drain_results();
		program_regs(11'd6, 10'd3, 10'd20);
		repeat (30)
			send_pixel(rand_px(), 1'b0);
		stop_input();
		drain_results();
		program_regs(11'd3, 10'd2, 10'd2);
		repeat (10)
			send_pixel(rand_px(), 1'b0);
		stop_input();
		drain_results();
		frames_sent++;
	endtask

	// random settings and frames: mostly whole frames, some cut, overrun or stray pixels
	task automatic test_random_frames;
		int          stop_at, nframes, len;
		int unsigned w, r, flen;
		frame_kind_t kind;
		logic [LW_W-1:0]   lw_v;
		logic [ROWS_W-1:0] rows_v;
		logic [OFS_W-1:0]  ofs_v;
		stop_at = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < stop_at) begin
			if ($urandom_range(0, 11) == 0) begin
				lw_v   = LW_W'($urandom_range(64, 300));
				rows_v = ROWS_W'($urandom_range(1, 3));
			end else if ($urandom_range(0, 9) == 0) begin
				lw_v   = LW_W'($urandom_range(0, 1));
				rows_v = '0;
			end else begin
				lw_v   = LW_W'($urandom_range(2, 12));
				rows_v = ROWS_W'($urandom_range(1, 6));
			end
			case ($urandom_range(0, 9))
				0:       ofs_v = OFS_W'($urandom_range(0, 1023));
				1, 2:    ofs_v = OFS_W'($urandom_range(0, 800));
				default: ofs_v = OFS_W'($urandom_range(0, 40));
			endcase
			program_regs(lw_v, rows_v, ofs_v);
			src_idle_on  = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			w = (lw_v < fes_pkg::WIDTH_MIN) ? fes_pkg::WIDTH_MIN : lw_v;
			r = (rows_v < fes_pkg::ROWS_MIN) ? fes_pkg::ROWS_MIN : rows_v;
			flen = w * (r + 2);
			nframes = $urandom_range(1, 3);
			for (int f = 0; f < nframes; f++) begin
				case ($urandom_range(0, 9))
					0:       kind = FRM_CUT;
					1:       kind = FRM_OVERRUN;
					2:       kind = FRM_NOISE;
					default: kind = FRM_FULL;
				endcase
				case (kind)
					FRM_CUT:     len = $urandom_range(1, flen);
					FRM_OVERRUN: len = flen + $urandom_range(1, 2 * w);
					FRM_NOISE:   len = $urandom_range(1, 20);
					default:     len = flen;
				endcase
				// wide rows: only enough of the frame to reach the stencil region
				if (w > 32 && len > 2 * w + 64)
					len = 2 * w + $urandom_range(0, 64);
				for (int i = 0; i < len; i++)
					send_pixel(rand_px(), i == 0 && kind != FRM_NOISE);
				if (kind != FRM_NOISE)
					frames_sent++;
			end
			stop_input();
			drain_results();
		end
	endtask

	// no idling on either side: two whole frames back to back, then a short overrun
	task automatic test_back_to_back;
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		program_regs(11'd8, 10'd8, 10'd6);
		for (int f = 0; f < 2; f++)
			for (int i = 0; i < 80; i++)
				send_pixel(rand_px(), i == 0);
		for (int i = 0; i < 8; i++)
			send_pixel(rand_px(), 1'b0);
		stop_input();
		drain_results();
		frames_sent += 2;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_small_frame_extremes();
		test_mid_frame_change();
		test_random_frames();
		test_back_to_back();
		repeat (20) @(posedge clk);
		$display("Covered %0d pixels in %0d frames under %0d register settings, %0d updated.",
			pixels_sent, frames_sent, settings_used, updates_seen);
		$display("Extremes, clamped registers, mid-frame changes and back-to-back frames run.");
		if (err_count == 0 && pending_pixels.size() == 0)
			$display("fire_effect_stencil_test passed");
		else
			$display("fire_effect_stencil_test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fes_pkg.sv
rtl/fire_effect_stencil.sv
verif/fire_effect_stencil_test.sv
